FILE: hdl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the first-fit block allocator
// Heap geometry, field widths, controller-to-datapath command and status
// structs, and the table of heap words written after reset.
// ----------------------------------------------------------------------------
package fba_pkg;

	// heap geometry
	localparam int HEAP_BYTES      = 65536;
	localparam int WORD_BYTES      = 8;
	localparam int ALIGN_BYTES     = 16;
	localparam int MIN_SPLIT_BYTES = 32;
	localparam int FIRST_PAYLOAD   = 16;
	localparam int RESET_BREAK     = 64;

	localparam int HEAP_AW    = $clog2(HEAP_BYTES);
	localparam int HEAP_WORDS = HEAP_BYTES / WORD_BYTES;
	localparam int WIDX_W     = $clog2(HEAP_WORDS);

	// field and word widths
	localparam int WORD_W = 17;
	localparam int REQ_W  = 17;
	localparam int OFS_W  = 16;
	localparam int NEED_W = REQ_W + 1;

	// byte address arithmetic, wide enough that a wrapped negative value
	// lands above the heap end
	localparam int ADDR_W = ((HEAP_AW > WORD_W) ? HEAP_AW : WORD_W) + 3;
	localparam int BRK_W  = HEAP_AW + 1;

	localparam logic [WORD_W-1:0] ALLOC_BIT = WORD_W'(1);
	localparam logic [WORD_W-1:0] SIZE_MASK = ~WORD_W'(ALIGN_BYTES - 1);

	// words written by the init sequence
	localparam int INIT_WORDS = 6;
	localparam int INIT_W     = $clog2(INIT_WORDS);

	// address selection for the single memory port
	typedef enum logic [1:0] {
		A_BP_HDR,       // bp - 8
		A_BP_NEED_FTR,  // bp + need - 16
		A_BP_NEED_HDR,  // bp + need - 8
		A_BP_HAVE_FTR   // bp + have - 16
	} addr_sel_t;

	// write data selection
	typedef enum logic [2:0] {
		D_NEED_A,  // need | alloc
		D_HAVE_A,  // have | alloc
		D_HAVE,    // have, free
		D_REST,    // have - need, free
		D_ONE      // epilogue
	} data_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic              wr_en;
		addr_sel_t         addr;
		data_sel_t         data;
		logic              init_en;
		logic [INIT_W-1:0] init_idx;
		logic              bp_adv;
		logic              latch_have;
		logic              grow_set;
		logic              out_load;
		logic              out_ok;
		logic              out_ofs;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_free;
		logic req_zero;
		logic off_zero;
		logic blk_end;
		logic blk_fit;
		logic split;
		logic can_grow;
	} status_t;

	// word index of each init entry
	function automatic logic [WIDX_W-1:0] init_index(input logic [INIT_W-1:0] i);
		logic [WIDX_W-1:0] r;
		unique case (i)
			INIT_W'(0): r = WIDX_W'(0);
			INIT_W'(1): r = WIDX_W'(1);
			INIT_W'(2): r = WIDX_W'(2);
			INIT_W'(3): r = WIDX_W'(3);
			INIT_W'(4): r = WIDX_W'(6);
			default:    r = WIDX_W'(7);
		endcase
		return r;
	endfunction

	// pad, prologue header and footer, free block tags, epilogue
	function automatic logic [WORD_W-1:0] init_data(input logic [INIT_W-1:0] i);
		logic [WORD_W-1:0] r;
		unique case (i)
			INIT_W'(0): r = WORD_W'(0);
			INIT_W'(1): r = WORD_W'(ALIGN_BYTES) | ALLOC_BIT;
			INIT_W'(2): r = WORD_W'(ALIGN_BYTES) | ALLOC_BIT;
			INIT_W'(3): r = WORD_W'(RESET_BREAK - 2 * ALIGN_BYTES);
			INIT_W'(4): r = WORD_W'(RESET_BREAK - 2 * ALIGN_BYTES);
			default:    r = ALLOC_BIT;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top: boundary-tag first-fit heap allocator
// Allocate walks block headers from the prologue and takes the first free
// block that fits, splitting it or growing the heap at the break; free
// clears the allocated bit in header and footer.
// ----------------------------------------------------------------------------
// Sequence: allocate reads each block header visited, then writes the block
//   tags, none when the heap is full; free reads the header, then writes
//   header and footer; zero requests and null frees end at dispatch; the
//   registered result is loaded last.
// Throughput: one transfer at a time, the walk over the single heap port
//   sets the rate; the next transfer is taken while a result waits.
// Reset: asynchronous, active low; afterwards the initial heap words are
//   written with input stalled, and the break restarts at 64.
module first_fit_block_allocator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [fba_pkg::REQ_W-1:0] request_bytes,
	input  logic [fba_pkg::OFS_W-1:0] payload_offset,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [fba_pkg::OFS_W-1:0] result_offset,
	output logic                      success
);

	fba_pkg::cmd_t    cmd;
	fba_pkg::status_t status;

	// sequencer
	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// heap memory and registers
	fba_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.func           (func),
		.request_bytes  (request_bytes),
		.payload_offset (payload_offset),
		.status         (status),
		.result_offset  (result_offset),
		.success        (success)
	);

endmodule

FILE: hdl/fba_datapath.sv
// ----------------------------------------------------------------------------
// fba_datapath: heap memory, block pointer and size registers
// Holds the heap word memory with one registered port, the walk pointer,
// the request size, the break and the result registers.
// ----------------------------------------------------------------------------
module fba_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fba_pkg::cmd_t               cmd,
	input  logic                        func,
	input  logic [fba_pkg::REQ_W-1:0]   request_bytes,
	input  logic [fba_pkg::OFS_W-1:0]   payload_offset,
	output fba_pkg::status_t            status,
	output logic [fba_pkg::OFS_W-1:0]   result_offset,
	output logic                        success
);

	localparam int AW = fba_pkg::ADDR_W;
	localparam int WW = fba_pkg::WORD_W;
	localparam int NW = fba_pkg::NEED_W;

	logic [WW-1:0] mem_q [fba_pkg::HEAP_WORDS];

	logic [AW-1:0]               bp_q;
	logic [NW-1:0]               need_q;
	logic [WW-1:0]               sz_q;
	logic [fba_pkg::BRK_W-1:0]   break_q;
	logic                        func_q;
	logic                        req_zero_q;
	logic                        off_zero_q;
	logic [WW-1:0]               rdata_q;
	logic                        oor_q;
	logic [fba_pkg::OFS_W-1:0]   result_offset_q;
	logic                        success_q;

	logic [NW-1:0]               need_d;
	logic [NW-1:0]               need_sum;
	logic [AW-1:0]               need_ext;
	logic [AW-1:0]               have_ext;
	logic [AW-1:0]               addr;
	logic                        in_range;
	logic [WW-1:0]               wdata;
	logic [fba_pkg::WIDX_W-1:0]  widx;
	logic                        we;
	logic [WW-1:0]               word_rd;
	logic [WW-1:0]               sz_rd;
	logic [WW-1:0]               rest;
	logic [AW-1:0]               grown;

	// request size rounded up with room for header and footer
	assign need_sum = NW'(request_bytes)
		+ NW'(fba_pkg::WORD_BYTES + fba_pkg::ALIGN_BYTES - 1);
	assign need_d = (need_sum & ~NW'(fba_pkg::ALIGN_BYTES - 1))
		+ NW'(2 * fba_pkg::WORD_BYTES);

	assign need_ext = AW'(need_q);
	assign have_ext = AW'(sz_q);

	// byte address of the memory port
	always_comb begin
		unique case (cmd.addr)
			fba_pkg::A_BP_HDR:      addr = bp_q - AW'(fba_pkg::WORD_BYTES);
			fba_pkg::A_BP_NEED_FTR: addr = bp_q + need_ext - AW'(2 * fba_pkg::WORD_BYTES);
			fba_pkg::A_BP_NEED_HDR: addr = bp_q + need_ext - AW'(fba_pkg::WORD_BYTES);
			fba_pkg::A_BP_HAVE_FTR: addr = bp_q + have_ext - AW'(2 * fba_pkg::WORD_BYTES);
			default:                addr = bp_q - AW'(fba_pkg::WORD_BYTES);
		endcase
	end

	assign in_range = addr < AW'(fba_pkg::HEAP_BYTES);

	// remainder after a split
	assign rest = sz_q - need_q[WW-1:0];

	// write data
	always_comb begin
		unique case (cmd.data)
			fba_pkg::D_NEED_A: wdata = need_q[WW-1:0] | fba_pkg::ALLOC_BIT;
			fba_pkg::D_HAVE_A: wdata = sz_q | fba_pkg::ALLOC_BIT;
			fba_pkg::D_HAVE:   wdata = sz_q;
			fba_pkg::D_REST:   wdata = rest;
			fba_pkg::D_ONE:    wdata = fba_pkg::ALLOC_BIT;
			default:           wdata = sz_q;
		endcase
	end

	// write port: init table or the selected address, dropped off the heap
	always_comb begin
		if (cmd.init_en) begin
			widx = fba_pkg::init_index(cmd.init_idx);
			we   = 1'b1;
		end else begin
			widx = addr[fba_pkg::HEAP_AW-1:3];
			we   = cmd.wr_en && in_range;
		end
	end

	// heap memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[widx] <= cmd.init_en ? fba_pkg::init_data(cmd.init_idx) : wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[addr[fba_pkg::HEAP_AW-1:3]];
			oor_q   <= !in_range;
		end
	end

	// read word decode; off-heap reads give zero
	assign word_rd = oor_q ? '0 : rdata_q;
	assign sz_rd   = word_rd & fba_pkg::SIZE_MASK;
	assign grown   = AW'(break_q) + need_ext;

	// request, pointer and size registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			need_q     <= need_d;
			req_zero_q <= request_bytes == '0;
			off_zero_q <= payload_offset == '0;
			bp_q       <= func ? AW'(payload_offset) : AW'(fba_pkg::FIRST_PAYLOAD);
		end else if (cmd.bp_adv) begin
			bp_q <= bp_q + AW'(sz_rd);
		end else if (cmd.grow_set) begin
			bp_q <= AW'(break_q);
		end
		if (cmd.latch_have) begin
			sz_q <= sz_rd;
		end
		if (cmd.grow_set) begin
			sz_q <= need_q[WW-1:0];
		end
		if (cmd.out_load) begin
			result_offset_q <= cmd.out_ofs ? bp_q[fba_pkg::OFS_W-1:0] : '0;
			success_q       <= cmd.out_ok;
		end
	end

	// heap break
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_q <= fba_pkg::BRK_W'(fba_pkg::RESET_BREAK);
		end else if (cmd.grow_set) begin
			break_q <= grown[fba_pkg::BRK_W-1:0];
		end
	end

	// status back to the controller
	always_comb begin
		status.is_free  = func_q;
		status.req_zero = req_zero_q;
		status.off_zero = off_zero_q;
		status.blk_end  = sz_rd == '0;
		status.blk_fit  = !word_rd[0] && (NW'(sz_rd) >= need_q);
		status.split    = rest >= WW'(fba_pkg::MIN_SPLIT_BYTES);
		status.can_grow = grown <= AW'(fba_pkg::HEAP_BYTES);
	end

	assign result_offset = result_offset_q;
	assign success       = success_q;

	// break stays aligned and inside the heap
	a_break_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(AW'(break_q) <= AW'(fba_pkg::HEAP_BYTES)) && (break_q[3:0] == 4'd0))
		else $error("heap break out of bounds or misaligned");

	// an allocated payload offset is always aligned
	a_result_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && cmd.out_ofs |-> bp_q[3:0] == 4'd0)
		else $error("allocated payload offset misaligned");

	// one access per cycle on the memory port
	a_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && (cmd.wr_en || cmd.init_en)))
		else $error("read and write on the heap port in one cycle");

endmodule

FILE: hdl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl: allocator sequencer
// Runs the heap init after reset, then for each transfer the first-fit
// walk, the split or grow writes, or the free writes, and loads the result.
// ----------------------------------------------------------------------------
module fba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  fba_pkg::status_t status,
	output fba_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_PL_HDR,
		ST_PL_FTR,
		ST_PL_RHDR,
		ST_PL_RFTR,
		ST_GR_SET,
		ST_GR_HDR,
		ST_GR_FTR,
		ST_GR_EPI,
		ST_FR_CHK,
		ST_FR_HDR,
		ST_FR_FTR
	} state_t;

	// the finish state shares the code space through a flag
	state_t                      state_q;
	logic                        fin_q;
	logic [fba_pkg::INIT_W-1:0]  init_q;
	logic                        out_valid_q;
	logic                        fin_ok_q;
	logic                        fin_ofs_q;
	logic                        slot_free;
	logic                        accept;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !(state_q == ST_IDLE && !fin_q);

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.addr       = fba_pkg::A_BP_HDR;
		cmd.data       = fba_pkg::D_HAVE;
		cmd.init_idx   = init_q;
		cmd.out_ok     = fin_ok_q;
		cmd.out_ofs    = fin_ofs_q;
		if (fin_q) begin
			cmd.out_load = slot_free;
		end else begin
			unique case (state_q)
				ST_INIT:     cmd.init_en = 1'b1;
				ST_IDLE:     cmd.load = accept;
				ST_DISPATCH: cmd.rd_en = 1'b1;
				ST_WALK_RD:  cmd.rd_en = 1'b1;
				ST_WALK_CHK: begin
					cmd.latch_have = status.blk_fit && !status.blk_end;
					cmd.bp_adv     = !status.blk_fit && !status.blk_end;
				end
				ST_PL_HDR: begin
					cmd.wr_en = 1'b1;
					cmd.data  = status.split ? fba_pkg::D_NEED_A : fba_pkg::D_HAVE_A;
				end
				ST_PL_FTR: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = status.split ? fba_pkg::A_BP_NEED_FTR : fba_pkg::A_BP_HAVE_FTR;
					cmd.data  = status.split ? fba_pkg::D_NEED_A : fba_pkg::D_HAVE_A;
				end
				ST_PL_RHDR: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = fba_pkg::A_BP_NEED_HDR;
					cmd.data  = fba_pkg::D_REST;
				end
				ST_PL_RFTR: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = fba_pkg::A_BP_HAVE_FTR;
					cmd.data  = fba_pkg::D_REST;
				end
				ST_GR_SET:   cmd.grow_set = 1'b1;
				ST_GR_HDR: begin
					cmd.wr_en = 1'b1;
					cmd.data  = fba_pkg::D_NEED_A;
				end
				ST_GR_FTR: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = fba_pkg::A_BP_NEED_FTR;
					cmd.data  = fba_pkg::D_NEED_A;
				end
				ST_GR_EPI: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = fba_pkg::A_BP_NEED_HDR;
					cmd.data  = fba_pkg::D_ONE;
				end
				ST_FR_CHK:   cmd.latch_have = 1'b1;
				ST_FR_HDR:   cmd.wr_en = 1'b1;
				ST_FR_FTR: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = fba_pkg::A_BP_HAVE_FTR;
				end
				default: ;
			endcase
		end
	end

	// state, finish flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			fin_q       <= 1'b0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
			fin_ok_q    <= 1'b0;
			fin_ofs_q   <= 1'b0;
		end else begin
			// result register: load on finish, drop on transfer
			if (fin_q && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (fin_q) begin
				if (slot_free) begin
					fin_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
			end else begin
				unique case (state_q)
					ST_INIT: begin
						init_q <= init_q + 1'b1;
						if (init_q == fba_pkg::INIT_W'(fba_pkg::INIT_WORDS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							state_q <= ST_DISPATCH;
						end
					end
					ST_DISPATCH: begin
						if (status.is_free) begin
							if (status.off_zero) begin
								fin_q     <= 1'b1;
								fin_ok_q  <= 1'b0;
								fin_ofs_q <= 1'b0;
							end else begin
								state_q <= ST_FR_CHK;
							end
						end else if (status.req_zero) begin
							fin_q     <= 1'b1;
							fin_ok_q  <= 1'b0;
							fin_ofs_q <= 1'b0;
						end else begin
							state_q <= ST_WALK_CHK;
						end
					end
					ST_WALK_RD:  state_q <= ST_WALK_CHK;
					ST_WALK_CHK: begin
						if (status.blk_end) begin
							if (status.can_grow) begin
								state_q <= ST_GR_SET;
							end else begin
								fin_q     <= 1'b1;
								fin_ok_q  <= 1'b0;
								fin_ofs_q <= 1'b0;
							end
						end else if (status.blk_fit) begin
							state_q <= ST_PL_HDR;
						end else begin
							state_q <= ST_WALK_RD;
						end
					end
					ST_PL_HDR:   state_q <= ST_PL_FTR;
					ST_PL_FTR: begin
						if (status.split) begin
							state_q <= ST_PL_RHDR;
						end else begin
							fin_q     <= 1'b1;
							fin_ok_q  <= 1'b1;
							fin_ofs_q <= 1'b1;
						end
					end
					ST_PL_RHDR:  state_q <= ST_PL_RFTR;
					ST_PL_RFTR: begin
						fin_q     <= 1'b1;
						fin_ok_q  <= 1'b1;
						fin_ofs_q <= 1'b1;
					end
					ST_GR_SET:   state_q <= ST_GR_HDR;
					ST_GR_HDR:   state_q <= ST_GR_FTR;
					ST_GR_FTR:   state_q <= ST_GR_EPI;
					ST_GR_EPI: begin
						fin_q     <= 1'b1;
						fin_ok_q  <= 1'b1;
						fin_ofs_q <= 1'b1;
					end
					ST_FR_CHK:   state_q <= ST_FR_HDR;
					ST_FR_HDR:   state_q <= ST_FR_FTR;
					ST_FR_FTR: begin
						fin_q     <= 1'b1;
						fin_ok_q  <= 1'b1;
						fin_ofs_q <= 1'b0;
					end
					default:     state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;

	// a new result appears only out of the finish step
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin_q))
		else $error("result valid raised outside finish");

	// no heap read or write while idle or in the finish step
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || fin_q) |-> !cmd.wr_en && !cmd.rd_en)
		else $error("heap access while idle");

endmodule
